### sv/fbf_pkg.sv
`timescale 1ns / 1ps
// Package with the operation codes and the controller/datapath command and status types.
package fbf_pkg;

	// Operation codes carried in the op field of a request.
	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_PUSH  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Widths of the fixed request and result fields.
	localparam int unsigned LenW  = 7;
	localparam int unsigned FlenW = 16;
	localparam int unsigned DropW = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;     // request transfer: run put, push or clear, start a read
		logic len_chk;  // clip the head length and decide whether the read is empty
		logic byte_rd;  // read the next ring byte and advance the head
		logic byte_ld;  // load the fetched byte into the result register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;   // the request waiting at the input is a read
		logic len_zero;  // the length queue is empty or the clipped read length is zero
		logic out_last;  // the held result is the final one of its request
	} dp_sts_t;

endpackage

### sv/fbf_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces with valid/ready handshake.
interface fbf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_in;
	logic [15:0] frame_length;
	logic [6:0] max_bytes;

	modport source (output valid, output op, output data_in, output frame_length,
		output max_bytes, input ready);
	modport sink (input valid, input op, input data_in, input frame_length,
		input max_bytes, output ready);
endinterface

interface fbf_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [7:0]  data_out;
	logic        data_valid;
	logic        last;
	logic [6:0]  read_length;
	logic        frame_pending;
	logic [15:0] drops;

	modport source (output valid, output status, output data_out, output data_valid,
		output last, output read_length, output frame_pending, output drops,
		input ready);
	modport sink (input valid, input status, input data_out, input data_valid,
		input last, input read_length, input frame_pending, input drops,
		output ready);
endinterface

### sv/fbf_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
module fbf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/fbf_datapath.sv
`timescale 1ns / 1ps
// Datapath: byte ring, length queue, drop counter and the result register.
module fbf_datapath import fbf_pkg::*; #(
	parameter int unsigned RING_DEPTH        = 256,
	parameter int unsigned FRAME_QUEUE_DEPTH = 8,
	parameter int unsigned MAX_READ          = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic [1:0]       op,
	input  logic [7:0]       data_in,
	input  logic [FlenW-1:0] frame_length,
	input  logic [LenW-1:0]  max_bytes,
	output logic             status,
	output logic [7:0]       data_out,
	output logic             data_valid,
	output logic             last,
	output logic [LenW-1:0]  read_length,
	output logic             frame_pending,
	output logic [DropW-1:0] drops
);

	localparam int unsigned RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned RFW = $clog2(RING_DEPTH + 1);
	localparam int unsigned QAW = (FRAME_QUEUE_DEPTH > 1) ? $clog2(FRAME_QUEUE_DEPTH) : 1;
	localparam int unsigned QFW = $clog2(FRAME_QUEUE_DEPTH + 1);
	localparam int unsigned CW  = (RFW > LenW) ? RFW : LenW;

	op_t              op_e;
	logic [RAW-1:0]   bhead_q, btail_q;
	logic [RFW-1:0]   bfill_q;
	logic [QAW-1:0]   lhead_q, ltail_q;
	logic [QFW-1:0]   lfill_q;
	logic [DropW-1:0] drop_q;
	logic [LenW-1:0]  cnt_q, len_q, maxb_q;
	logic             last_q;
	logic [7:0]       bdata;
	logic [FlenW-1:0] ldata;
	logic             ring_space, lq_full, lq_empty, flen_nz;
	logic             byte_we, len_we, len_re;
	logic [LenW-1:0]  clip_max, clip_len, maxb_sat;

	assign op_e = op_t'(op);

	// Occupancy flags of the two queues.
	assign ring_space = (bfill_q < RFW'(RING_DEPTH));
	assign lq_full    = (lfill_q >= QFW'(FRAME_QUEUE_DEPTH));
	assign lq_empty   = (lfill_q == '0);
	assign flen_nz    = (frame_length != '0);

	// Memory write and read strobes.
	assign byte_we = cmd.exec && (op_e == OP_PUT) && ring_space;
	assign len_we  = cmd.exec && (op_e == OP_PUSH) && flen_nz && !lq_full;
	assign len_re  = cmd.exec && (op_e == OP_READ);

	fbf_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (btail_q),
		.wdata (data_in),
		.re    (cmd.byte_rd),
		.raddr (bhead_q),
		.rdata (bdata)
	);

	fbf_ram #(.WIDTH(FlenW), .DEPTH(FRAME_QUEUE_DEPTH)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (ltail_q),
		.wdata (frame_length),
		.re    (len_re),
		.raddr (lhead_q),
		.rdata (ldata)
	);

	// Saturate the reader maximum, then clip the head length to it and to the bytes held.
	assign maxb_sat = (max_bytes > LenW'(MAX_READ)) ? LenW'(MAX_READ) : max_bytes;
	assign clip_max = (ldata > FlenW'(maxb_q)) ? maxb_q : ldata[LenW-1:0];
	assign clip_len = (CW'(clip_max) > CW'(bfill_q)) ? LenW'(bfill_q) : clip_max;

	assign sts.is_read  = (op_e == OP_READ);
	assign sts.len_zero = lq_empty || (clip_len == '0);
	assign sts.out_last = last_q;

	// Queue pointers, fill counts, drop counter and byte count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bhead_q <= '0;
			btail_q <= '0;
			bfill_q <= '0;
			lhead_q <= '0;
			ltail_q <= '0;
			lfill_q <= '0;
			drop_q  <= '0;
			cnt_q   <= '0;
			last_q  <= 1'b1;
		end else begin
			if (cmd.exec) begin
				unique case (op_e)
					OP_PUT: begin
						if (ring_space) begin
							btail_q <= (btail_q == RAW'(RING_DEPTH - 1)) ? '0 : btail_q + 1'b1;
							bfill_q <= bfill_q + 1'b1;
						end
						last_q <= 1'b1;
					end
					OP_PUSH: begin
						if (flen_nz) begin
							if (lq_full) begin
								drop_q <= drop_q + 1'b1;
							end else begin
								ltail_q <= (ltail_q == QAW'(FRAME_QUEUE_DEPTH - 1)) ?
									'0 : ltail_q + 1'b1;
								lfill_q <= lfill_q + 1'b1;
							end
						end
						last_q <= 1'b1;
					end
					OP_READ: begin
					end
					OP_CLEAR: begin
						bhead_q <= '0;
						btail_q <= '0;
						bfill_q <= '0;
						lhead_q <= '0;
						ltail_q <= '0;
						lfill_q <= '0;
						last_q  <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.len_chk) begin
				if (sts.len_zero) begin
					last_q <= 1'b1;
				end else begin
					lhead_q <= (lhead_q == QAW'(FRAME_QUEUE_DEPTH - 1)) ? '0 : lhead_q + 1'b1;
					lfill_q <= lfill_q - 1'b1;
					cnt_q   <= '0;
				end
			end
			if (cmd.byte_rd) begin
				bhead_q <= (bhead_q == RAW'(RING_DEPTH - 1)) ? '0 : bhead_q + 1'b1;
				bfill_q <= bfill_q - 1'b1;
				cnt_q   <= cnt_q + 1'b1;
			end
			if (cmd.byte_ld) begin
				last_q <= (cnt_q == len_q);
			end
		end
	end

	// Result payload, clipped length and saturated reader maximum.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			maxb_q      <= maxb_sat;
			data_out    <= '0;
			data_valid  <= 1'b0;
			read_length <= '0;
			unique case (op_e)
				OP_PUT:   status <= !ring_space;
				OP_PUSH:  status <= !(flen_nz && !lq_full);
				OP_READ:  status <= 1'b1;
				OP_CLEAR: status <= 1'b0;
				default:  status <= 1'b1;
			endcase
		end
		if (cmd.len_chk) begin
			len_q <= clip_len;
			if (sts.len_zero) begin
				status      <= 1'b1;
				data_out    <= '0;
				data_valid  <= 1'b0;
				read_length <= '0;
			end
		end
		if (cmd.byte_ld) begin
			status      <= 1'b0;
			data_out    <= bdata;
			data_valid  <= 1'b1;
			read_length <= len_q;
		end
	end

	assign last          = last_q;
	assign frame_pending = !lq_empty;
	assign drops         = drop_q;

endmodule

### sv/fbf_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one request at a time through the datapath.
module fbf_ctrl import fbf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_LEN_CHK = 5'b00010,
		ST_BYTE_RD = 5'b00100,
		ST_BYTE_LD = 5'b01000,
		ST_OUT     = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_OUT);

	// Commands decoded from the state.
	assign cmd.exec    = (state_q == ST_IDLE) && req_valid;
	assign cmd.len_chk = (state_q == ST_LEN_CHK);
	assign cmd.byte_rd = (state_q == ST_BYTE_RD);
	assign cmd.byte_ld = (state_q == ST_BYTE_LD);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = sts.is_read ? ST_LEN_CHK : ST_OUT;
				end
			end
			ST_LEN_CHK: begin
				state_d = sts.len_zero ? ST_OUT : ST_BYTE_RD;
			end
			ST_BYTE_RD: begin
				state_d = ST_BYTE_LD;
			end
			ST_BYTE_LD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (rsp_ready) begin
					state_d = sts.out_last ? ST_IDLE : ST_BYTE_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/framed_byte_fifo_top.sv
`timescale 1ns / 1ps
// Top level of the framed byte FIFO: controller, datapath and channel wiring.
//
//   channel | dir | fields
//   --------+-----+-----------------------------------------------------------------
//   req     | in  | op, data_in, frame_length, max_bytes
//   rsp     | out | status, data_out, data_valid, last, read_length, frame_pending, drops
//
// One request is in flight at a time. Put, push and clear execute when the request
// is taken; the result is then offered and held until rsp.ready.
// A read first reads the length memory and then clips the length; each byte then
// takes a ring read, a result load and a result transfer.
// Reset empties both queues and clears the drop counter; memories are not cleared.
// A stall on rsp holds the result and stops the sequencer; req.ready is low meanwhile.
module framed_byte_fifo_top import fbf_pkg::*; #(
	parameter int unsigned RING_DEPTH        = 256,
	parameter int unsigned FRAME_QUEUE_DEPTH = 8,
	parameter int unsigned MAX_READ          = 64
) (
	input logic       clk,
	input logic       arst_n,
	fbf_req_if.sink   req,
	fbf_rsp_if.source rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	fbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fbf_datapath #(
		.RING_DEPTH        (RING_DEPTH),
		.FRAME_QUEUE_DEPTH (FRAME_QUEUE_DEPTH),
		.MAX_READ          (MAX_READ)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (req.op),
		.data_in       (req.data_in),
		.frame_length  (req.frame_length),
		.max_bytes     (req.max_bytes),
		.status        (rsp.status),
		.data_out      (rsp.data_out),
		.data_valid    (rsp.data_valid),
		.last          (rsp.last),
		.read_length   (rsp.read_length),
		.frame_pending (rsp.frame_pending),
		.drops         (rsp.drops)
	);

endmodule
